### sv/nci_pkg.sv
// shared types and constants for the normalized channel index block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package nci_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int PRICE_BITS_DEF = 24;

  localparam int LEN_BITS   = 7;
  localparam int SCALE_BITS = 10;
  localparam int CFG_BITS   = 10;

  localparam logic [LEN_BITS-1:0]   LEN_RESET   = 7'd20;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 10'd200;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_SCALE_LIMIT   = 1'b1;

  // quotient bits of the final fraction
  localparam int QBITS = 15;
  localparam int OUT_BITS = 16;

  typedef struct packed {
    logic shift;
    logic rotate;
  } nci_cell_ctrl_t;

endpackage
`default_nettype wire

### sv/nci_cell.sv
// one window cell: holds a typical-price sum, shifts in or rotates
// depends on nci_pkg
`timescale 1ns / 1ps
`default_nettype none
module nci_cell #(
  parameter int W = 26
) (
  input  wire                        clk,
  input  wire nci_pkg::nci_cell_ctrl_t ctrl,
  input  wire                        is_last,
  input  wire  [W-1:0]               left_i,
  input  wire  [W-1:0]               right_i,
  input  wire  [W-1:0]               head_i,
  output logic [W-1:0]               q_o
);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift) begin
      val_nxt = left_i;
    end else if (ctrl.rotate) begin
      val_nxt = is_last ? head_i : right_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q_o = val_r;

endmodule
`default_nettype wire

### sv/nci_div.sv
// restoring divider, one quotient bit per cycle, for a < b
// depends on nci_pkg
`timescale 1ns / 1ps
`default_nettype none
module nci_div #(
  parameter int BW = 52
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [BW-1:0]                a,
  input  wire  [BW-1:0]                b,
  output logic                         done,
  output logic [nci_pkg::QBITS-1:0]    q,
  output logic                         rem_nz
);

  localparam int CW = $clog2(nci_pkg::QBITS + 1);

  logic [BW-1:0]             rem_r, rem_nxt;
  logic [BW-1:0]             b_r;
  logic [nci_pkg::QBITS-1:0] q_r, q_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [BW:0]               rem2;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem2     = {rem_r, 1'b0};
    if (start) begin
      rem_nxt  = a;
      q_nxt    = '0;
      cnt_nxt  = CW'(nci_pkg::QBITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem2 >= {1'b0, b_r}) begin
        rem_nxt = BW'(rem2 - {1'b0, b_r});
        q_nxt   = {q_r[nci_pkg::QBITS-2:0], 1'b1};
      end else begin
        rem_nxt = BW'(rem2);
        q_nxt   = {q_r[nci_pkg::QBITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      b_r <= b;
    end
  end

  assign done   = done_r;
  assign q      = q_r;
  assign rem_nz = (rem_r != '0);

endmodule
`default_nettype wire

### sv/normalized_channel_index.sv
// normalized channel index: top level with window cell chain, control and divider
// depends on nci_pkg, nci_cell, nci_div
//
// usage:
//   in_*  : one candle per transfer, tdata = {close, low, high}, high in the low bits
//   out_* : one normalized index per candle once the window is full, unsigned Q0.16
//   cfg_* : register writes while idle; index 0 window length, index 1 scale limit
// the window is a row of cells; a new candle shifts into the first cell, then the
// first n cells rotate twice around: once for the window sum, once for the sum of
// absolute deviations (n is the window length, clamped to 1..WINDOW_MAX)
// after an input transfer the control steps through the two rotations, a drain step,
// the multiply and compare steps and the divide, then loads the output register;
// a result that saturates or sits at mid-scale skips the divide. one candle is in
// work at a time: a new candle waits for the last result; warm-up candles stay in idle
// the first n-1 candles after reset or a window length write give no result
// reset clears control state and the fill count and restores the register defaults
// a result waits in the output register while the receiver stalls; the next candle
// is taken meanwhile and held back only at its own result
`timescale 1ns / 1ps
`default_nettype none
module normalized_channel_index #(
  parameter int WINDOW_MAX = nci_pkg::WINDOW_MAX_DEF,
  parameter int PRICE_BITS = nci_pkg::PRICE_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // high price, low price, close price
  input  wire  [((3*PRICE_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // normalized_index
  output logic [nci_pkg::OUT_BITS-1:0]           out_tdata,
  input  wire                                    cfg_we,
  input  wire                                    cfg_index,
  input  wire  [nci_pkg::CFG_BITS-1:0]           cfg_wdata
);

  localparam int TW  = PRICE_BITS + 2;
  localparam int NW  = $clog2(WINDOW_MAX + 1);
  localparam int SW  = TW + NW;
  localparam int DW  = SW + 1;
  localparam int DSW = TW + 2 * NW;
  localparam int NAW = NW + 8;
  localparam int AW  = NAW + SW;
  localparam int BW  = DSW + 12;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DEV   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [nci_pkg::LEN_BITS-1:0]  len_r;
  logic [nci_pkg::SCALE_BITS-1:0] scale_r;
  logic [NW-1:0]                 cnt_r, cnt_nxt;
  logic [NW-1:0]                 step_r, step_nxt;
  logic [NW-1:0]                 n_eff;
  logic [TW-1:0]                 t_in;
  logic [SW-1:0]                 s_r, s_nxt;
  logic [SW-1:0]                 prod_r;
  logic                          pv_r, pv_nxt;
  logic                          first_r, first_nxt;
  logic [DSW-1:0]                dsum_r, dsum_nxt;
  logic signed [DW-1:0]          dnew_r, dnew_nxt;
  logic signed [DW-1:0]          diff;
  logic [SW-1:0]                 diff_abs;
  logic [SW-1:0]                 mag;
  logic [NAW-1:0]                n200_r;
  logic [11:0]                   s3_r;
  logic [AW-1:0]                 a_r;
  logic [BW-1:0]                 b_r;
  logic                          div_start;
  logic                          div_done;
  logic [nci_pkg::QBITS-1:0]     div_q;
  logic                          div_nz;
  logic [nci_pkg::OUT_BITS-1:0]  res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [nci_pkg::OUT_BITS-1:0]  out_data_r, out_data_nxt;
  logic                          in_fire;
  logic                          len_write;
  nci_pkg::nci_cell_ctrl_t       cell_ctrl;
  logic [TW-1:0]                 cell_q [WINDOW_MAX];
  wire  [WINDOW_MAX-1:0]         is_last;

  always_comb begin
    if (len_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(len_r) > WINDOW_MAX) begin
      n_eff = NW'(WINDOW_MAX);
    end else begin
      n_eff = NW'(len_r);
    end
  end

  assign t_in = TW'(in_tdata[PRICE_BITS-1:0])
              + TW'(in_tdata[2*PRICE_BITS-1:PRICE_BITS])
              + TW'(in_tdata[3*PRICE_BITS-1:2*PRICE_BITS]);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign len_write = cfg_we && (cfg_index == nci_pkg::REG_WINDOW_LENGTH);

  assign cell_ctrl = '{shift: in_fire,
                       rotate: (state_r == ST_SUM) || (state_r == ST_DEV)};

  genvar k;
  generate
    for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
      assign is_last[k] = (n_eff - 1'b1) == NW'(k);
      nci_cell #(
        .W(TW)
      ) u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .is_last (is_last[k]),
        .left_i  ((k == 0) ? t_in : cell_q[(k == 0) ? 0 : k-1]),
        .right_i (cell_q[(k == WINDOW_MAX-1) ? 0 : k+1]),
        .head_i  (cell_q[0]),
        .q_o     (cell_q[k])
      );
    end
  endgenerate

  assign diff     = $signed({1'b0, prod_r}) - $signed({1'b0, s_r});
  assign diff_abs = diff[DW-1] ? SW'(-diff) : SW'(diff);
  assign mag      = dnew_r[DW-1] ? SW'(-dnew_r) : SW'(dnew_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    s_nxt         = s_r;
    pv_nxt        = 1'b0;
    first_nxt     = first_r;
    dsum_nxt      = dsum_r;
    dnew_nxt      = dnew_r;
    res_nxt       = res_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cnt_r < n_eff) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if ((NW+1)'(cnt_r) + 1'b1 >= (NW+1)'(n_eff)) begin
            state_nxt = ST_SUM;
            step_nxt  = '0;
            s_nxt     = '0;
          end
        end
      end
      ST_SUM: begin
        s_nxt    = s_r + SW'(cell_q[0]);
        step_nxt = step_r + 1'b1;
        if (step_r == n_eff - 1'b1) begin
          state_nxt = ST_DEV;
          step_nxt  = '0;
          dsum_nxt  = '0;
          first_nxt = 1'b1;
        end
      end
      ST_DEV: begin
        pv_nxt   = 1'b1;
        step_nxt = step_r + 1'b1;
        if (pv_r) begin
          dsum_nxt  = dsum_r + DSW'(diff_abs);
          first_nxt = 1'b0;
          if (first_r) begin
            dnew_nxt = diff;
          end
        end
        if (step_r == n_eff - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        dsum_nxt = dsum_r + DSW'(diff_abs);
        if (first_r) begin
          dnew_nxt = diff;
        end
        first_nxt = 1'b0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (dnew_r == '0) begin
          res_nxt   = 16'h8000;
          state_nxt = ST_DONE;
        end else if (BW'(a_r) >= b_r) begin
          res_nxt   = dnew_r[DW-1] ? 16'h0000 : 16'hFFFF;
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (dnew_r[DW-1]) begin
            res_nxt = 16'h8000 - {1'b0, div_q} - {15'd0, div_nz};
          end else begin
            res_nxt = {1'b1, div_q};
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (len_write) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      pv_r        <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= nci_pkg::LEN_RESET;
      scale_r     <= nci_pkg::SCALE_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      pv_r        <= pv_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == nci_pkg::REG_WINDOW_LENGTH) begin
          len_r <= cfg_wdata[nci_pkg::LEN_BITS-1:0];
        end else begin
          scale_r <= cfg_wdata[nci_pkg::SCALE_BITS-1:0];
        end
      end
    end
    s_r        <= s_nxt;
    dsum_r     <= dsum_nxt;
    dnew_r     <= dnew_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    prod_r     <= SW'(n_eff) * SW'(cell_q[0]);
    if (in_fire) begin
      n200_r <= NAW'(n_eff) * NAW'(200);
      s3_r   <= 12'((scale_r == '0) ? 12'd1 : 12'(scale_r)) * 12'd3;
    end
    if (state_r == ST_MUL) begin
      a_r <= AW'(n200_r) * AW'(mag);
      b_r <= BW'(s3_r) * BW'(dsum_r);
    end
  end

  nci_div #(
    .BW(BW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .a      (BW'(a_r)),
    .b      (b_r),
    .done   (div_done),
    .q      (div_q),
    .rem_nz (div_nz)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
